// File: hdl/priority_load_shedding_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the load shedding controller
// Clocked, reset-qualified property wrappers.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LOAD_SHEDDING_CONTROLLER_ASSERT_SVH
`define PRIORITY_LOAD_SHEDDING_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PLSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plsc: same-cycle check failed");

// next-cycle implication
`define PLSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plsc: next-cycle check failed");

`endif

// File: hdl/plsc_pkg.sv
// ----------------------------------------------------------------------------
// Load shedding controller package
// Shared widths, parameter defaults and register indexes.
// ----------------------------------------------------------------------------
package plsc_pkg;

    localparam int GROUP_COUNT_DEF   = 8;
    localparam int PRIORITY_BITS_DEF = 4;
    localparam int POWER_BITS_DEF    = 16;

    localparam int LEVEL_W     = 16;
    localparam int TIME_W      = 32;
    localparam int MASK_W      = 8;
    localparam int PRIO_REG_W  = 32;
    localparam int TARGET_W    = 3;
    localparam int SHED_W      = 8;
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHED_ENABLE    = 3'd0,
        REG_WARNING_LEVEL  = 3'd1,
        REG_CRITICAL_LEVEL = 3'd2,
        REG_HOLD_SECONDS   = 3'd3,
        REG_GROUP_PRIO     = 3'd4,
        REG_NEVER_SHED     = 3'd5,
        REG_GROUP_PRESENT  = 3'd6
    } cfg_reg_t;

endpackage

// File: hdl/plsc_if.sv
// ----------------------------------------------------------------------------
// Load shedding controller channels
// Valid/ready channels for tick beats and result beats.
// ----------------------------------------------------------------------------
interface plsc_in_if #(
    parameter int POWER_BITS = plsc_pkg::POWER_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          meter_healthy;
    logic                          readings_valid;
    logic [POWER_BITS-1:0]         total_power;
    logic [plsc_pkg::TIME_W-1:0]   now_seconds;
    logic                          seq_busy;
    logic                          seq_ok;
    logic                          start_taken;

    modport source (
        output valid, meter_healthy, readings_valid, total_power, now_seconds,
               seq_busy, seq_ok, start_taken,
        input  ready
    );
    modport sink (
        input  valid, meter_healthy, readings_valid, total_power, now_seconds,
               seq_busy, seq_ok, start_taken,
        output ready
    );
endinterface

interface plsc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          warn_flag;
    logic                          crit_flag;
    logic                          shedding_active;
    logic                          start_request;
    logic [plsc_pkg::TARGET_W-1:0] target_group;
    logic [plsc_pkg::SHED_W-1:0]   shed_groups;

    modport source (
        output valid, warn_flag, crit_flag, shedding_active, start_request,
               target_group, shed_groups,
        input  ready
    );
    modport sink (
        input  valid, warn_flag, crit_flag, shedding_active, start_request,
               target_group, shed_groups,
        output ready
    );
endinterface

// File: hdl/priority_load_shedding_controller.sv
// ----------------------------------------------------------------------------
// Priority load shedding controller
// Timing: an accepted tick beat waits in the tick register, then its result
//   beat is registered in the result register. Throughput: one tick per cycle
//   unless results stall, set by the single-pass update between them.
// Reset: control state and valid flags cleared, configuration at its reset values.
// ----------------------------------------------------------------------------
module priority_load_shedding_controller #(
    parameter int GROUP_COUNT   = plsc_pkg::GROUP_COUNT_DEF,
    parameter int PRIORITY_BITS = plsc_pkg::PRIORITY_BITS_DEF,
    parameter int POWER_BITS    = plsc_pkg::POWER_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [plsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [plsc_pkg::CFG_W-1:0]       cfg_data,
    plsc_in_if.sink                          ticks,
    plsc_out_if.source                       results
);
    import plsc_pkg::*;

`include "priority_load_shedding_controller_assert.svh"

    localparam int IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int CMP_W = (POWER_BITS > LEVEL_W) ? POWER_BITS : LEVEL_W;

    // configuration
    logic                  enable_reg;
    logic [LEVEL_W-1:0]    warn_reg;
    logic [LEVEL_W-1:0]    crit_reg;
    logic [LEVEL_W-1:0]    hold_reg;
    logic [PRIO_REG_W-1:0] prio_reg;
    logic [MASK_W-1:0]     never_reg;
    logic [MASK_W-1:0]     present_reg;

    // tick register
    logic                  in_vld_reg;
    logic                  healthy_reg;
    logic                  rvalid_reg;
    logic [POWER_BITS-1:0] power_reg;
    logic [TIME_W-1:0]     now_reg;
    logic                  busy_reg;
    logic                  ok_reg;
    logic                  taken_reg;

    // control state
    logic                   shedding_reg,  shedding_next;
    logic                   timing_reg,    timing_next;
    logic [TIME_W-1:0]      start_reg,     start_next;
    logic [GROUP_COUNT-1:0] shed_reg,      shed_next;
    logic                   pend_vld_reg,  pend_vld_next;
    logic [IDX_W-1:0]       pend_idx_reg,  pend_idx_next;
    logic                   outst_reg,     outst_next;

    // result register
    logic                  out_vld_reg;
    logic                  warn_out_reg;
    logic                  crit_out_reg;
    logic                  shedding_out_reg;
    logic                  req_out_reg;
    logic [TARGET_W-1:0]   target_out_reg;
    logic [SHED_W-1:0]     shed_out_reg;

    logic                   advance;
    logic                   usable;
    logic                   warn;
    logic                   crit;
    logic                   pend_mid;
    logic [GROUP_COUNT-1:0] shed_mid;
    logic [TIME_W-1:0]      start_eff;
    logic [TIME_W-1:0]      elapsed;
    logic                   issue;
    logic                   sel_found;
    logic [IDX_W-1:0]       sel_best;

    assign advance      = in_vld_reg && (!out_vld_reg || results.ready);
    assign ticks.ready  = !in_vld_reg || !out_vld_reg || results.ready;

    assign usable = healthy_reg && rvalid_reg;
    assign warn   = usable && (CMP_W'(power_reg) >= CMP_W'(warn_reg));
    assign crit   = usable && (CMP_W'(power_reg) >= CMP_W'(crit_reg));

    plsc_select #(
        .GROUP_COUNT   (GROUP_COUNT),
        .PRIORITY_BITS (PRIORITY_BITS),
        .IDX_W         (IDX_W)
    ) u_select (
        .present (present_reg),
        .never   (never_reg),
        .shed    (shed_mid),
        .prio    (prio_reg),
        .found   (sel_found),
        .best    (sel_best)
    );

    // request resolution, then sequence completion
    always_comb
    begin
        pend_mid = pend_vld_reg || (outst_reg && taken_reg);
        shed_mid = shed_reg;
        if (pend_mid && !busy_reg && ok_reg)
        begin
            shed_mid = shed_reg | (GROUP_COUNT'(1) << pend_idx_reg);
        end
    end

    assign start_eff = timing_reg ? start_reg : now_reg;
    assign elapsed   = now_reg - start_eff;

    always_comb
    begin
        shedding_next = shedding_reg;
        timing_next   = timing_reg;
        start_next    = start_reg;
        shed_next     = shed_mid;
        pend_vld_next = pend_mid && busy_reg;
        pend_idx_next = pend_idx_reg;
        outst_next    = 1'b0;
        issue         = 1'b0;
        if (enable_reg && usable)
        begin
            if (!crit)
            begin
                timing_next = 1'b0;
                start_next  = '0;
                if (!warn)
                begin
                    shedding_next = 1'b0;
                end
            end
            else
            begin
                timing_next = 1'b1;
                start_next  = start_eff;
                if (elapsed >= TIME_W'(hold_reg))
                begin
                    shedding_next = 1'b1;
                    if (!busy_reg && sel_found)
                    begin
                        issue         = 1'b1;
                        pend_idx_next = sel_best;
                        outst_next    = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            warn_reg    <= '1;
            crit_reg    <= '1;
            hold_reg    <= LEVEL_W'(10);
            prio_reg    <= '0;
            never_reg   <= '1;
            present_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHED_ENABLE:    enable_reg  <= cfg_data[0];
                REG_WARNING_LEVEL:  warn_reg    <= cfg_data[LEVEL_W-1:0];
                REG_CRITICAL_LEVEL: crit_reg    <= cfg_data[LEVEL_W-1:0];
                REG_HOLD_SECONDS:   hold_reg    <= cfg_data[LEVEL_W-1:0];
                REG_GROUP_PRIO:     prio_reg    <= cfg_data[PRIO_REG_W-1:0];
                REG_NEVER_SHED:     never_reg   <= cfg_data[MASK_W-1:0];
                REG_GROUP_PRESENT:  present_reg <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shedding_reg <= 1'b0;
            timing_reg   <= 1'b0;
            start_reg    <= '0;
            shed_reg     <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            outst_reg    <= 1'b0;
        end
        else if (cfg_we && (cfg_index == REG_SHED_ENABLE) && !cfg_data[0])
        begin
            shedding_reg <= 1'b0;
            timing_reg   <= 1'b0;
            start_reg    <= '0;
        end
        else if (advance)
        begin
            shedding_reg <= shedding_next;
            timing_reg   <= timing_next;
            start_reg    <= start_next;
            shed_reg     <= shed_next;
            pend_vld_reg <= pend_vld_next;
            pend_idx_reg <= pend_idx_next;
            outst_reg    <= outst_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ticks.ready)
            begin
                in_vld_reg <= ticks.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ticks.valid && ticks.ready)
        begin
            healthy_reg <= ticks.meter_healthy;
            rvalid_reg  <= ticks.readings_valid;
            power_reg   <= ticks.total_power;
            now_reg     <= ticks.now_seconds;
            busy_reg    <= ticks.seq_busy;
            ok_reg      <= ticks.seq_ok;
            taken_reg   <= ticks.start_taken;
        end
        if (advance)
        begin
            warn_out_reg     <= warn;
            crit_out_reg     <= crit;
            shedding_out_reg <= shedding_next;
            req_out_reg      <= issue;
            target_out_reg   <= issue ? TARGET_W'(sel_best) : '0;
            shed_out_reg     <= SHED_W'(shed_next);
        end
    end

    assign results.valid           = out_vld_reg;
    assign results.warn_flag       = warn_out_reg;
    assign results.crit_flag       = crit_out_reg;
    assign results.shedding_active = shedding_out_reg;
    assign results.start_request   = req_out_reg;
    assign results.target_group    = target_out_reg;
    assign results.shed_groups     = shed_out_reg;

    `PLSC_ASSERT_NOW(a_req_needs_shed, clk, rst_n,
        results.valid && results.start_request, results.shedding_active)
    `PLSC_ASSERT_NOW(a_req_pend_excl, clk, rst_n, outst_reg, !pend_vld_reg)
    `PLSC_ASSERT_NEXT(a_shed_grows, clk, rst_n, 1'b1,
        (shed_reg & $past(shed_reg)) == $past(shed_reg))

endmodule

// File: hdl/plsc_select.sv
// ----------------------------------------------------------------------------
// Shed group selector
// Picks the eligible group with the highest priority, lowest index on ties.
// ----------------------------------------------------------------------------
module plsc_select #(
    parameter int GROUP_COUNT   = plsc_pkg::GROUP_COUNT_DEF,
    parameter int PRIORITY_BITS = plsc_pkg::PRIORITY_BITS_DEF,
    parameter int IDX_W         = 3
) (
    input  logic [plsc_pkg::MASK_W-1:0]     present,
    input  logic [plsc_pkg::MASK_W-1:0]     never,
    input  logic [GROUP_COUNT-1:0]          shed,
    input  logic [plsc_pkg::PRIO_REG_W-1:0] prio,
    output logic                            found,
    output logic [IDX_W-1:0]                best
);
    import plsc_pkg::*;

    localparam int PX_W = (GROUP_COUNT * PRIORITY_BITS > PRIO_REG_W)
                          ? GROUP_COUNT * PRIORITY_BITS : PRIO_REG_W;

    logic [GROUP_COUNT-1:0]   present_g;
    logic [GROUP_COUNT-1:0]   never_g;
    logic [GROUP_COUNT-1:0]   elig;
    logic [PX_W-1:0]          prio_ext;
    logic [PRIORITY_BITS-1:0] pr [GROUP_COUNT];
    logic [PRIORITY_BITS-1:0] best_p;

    // mask and priority bits above the register width read as zero
    assign present_g = GROUP_COUNT'(present);
    assign never_g   = GROUP_COUNT'(never);
    assign prio_ext  = PX_W'(prio);
    assign elig      = present_g & ~never_g & ~shed;

    always_comb
    begin
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            pr[i] = prio_ext[PRIORITY_BITS*i +: PRIORITY_BITS];
        end
    end

    always_comb
    begin
        found  = 1'b0;
        best   = '0;
        best_p = '0;
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            if (elig[i] && (!found || pr[i] > best_p))
            begin
                found  = 1'b1;
                best   = IDX_W'(i);
                best_p = pr[i];
            end
        end
    end

endmodule
